>>> src/array_access_stat_tracker_defines.svh
// ----------------------------------------------------------------------------
// array access stat tracker assertion macros
// Assertion helpers used by the tracker modules.
// ----------------------------------------------------------------------------
`ifndef ARRAY_ACCESS_STAT_TRACKER_DEFINES_SVH
`define ARRAY_ACCESS_STAT_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define AAST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define AAST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define AAST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AAST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> src/aast_pkg.sv
// ----------------------------------------------------------------------------
// aast_pkg
// Types and constants shared by the array access stat tracker.
// ----------------------------------------------------------------------------
package aast_pkg;
	localparam int Entries = 16;
	localparam int Slots = 64;
	localparam int EntW = $clog2(Entries);
	localparam int SlotW = $clog2(Slots);
	localparam int UsedW = $clog2(Entries + 1);
	localparam int DistW = 7;
	localparam int MemDepth = Entries * Slots;
	localparam int MemAw = $clog2(MemDepth);

	typedef struct packed {
		logic [31:0] arr_tag;
		logic signed [63:0] access_index;
	} in_word_t;

	typedef struct packed {
		logic found;
		logic [3:0] entry_number;
		logic [31:0] total_accesses;
		logic signed [63:0] lowest_index;
		logic signed [63:0] highest_index;
		logic [6:0] distinct_slots;
		logic negative_seen;
		logic [31:0] slot_hits;
		logic slot_was_new;
	} out_word_t;

	// per-cell update command
	typedef struct packed {
		logic [31:0] id;
		logic signed [63:0] idx;
		logic alloc;
		logic [EntW-1:0] alloc_sel;
	} cell_cmd_t;

	typedef struct packed {
		logic [31:0] count;
		logic signed [63:0] lo;
		logic signed [63:0] hi;
		logic neg;
		logic [DistW-1:0] dcount;
		logic fresh;
	} cell_stat_t;
endpackage

>>> src/array_access_stat_tracker.sv
// ----------------------------------------------------------------------------
// array_access_stat_tracker
// Per-array access statistics over a table of tracked identifiers.
// ----------------------------------------------------------------------------
// start is taken at an edge where busy is low, and at that edge the row of
// cells has already matched the id in parallel and the slot hit counter
// memory read is issued. busy is then high for one cycle while the
// registered read data comes back, the cell statistics update and the
// incremented counter is written. done is high for one cycle right after,
// and the next word can be taken while done is high. The result cannot be
// stalled by the receiver.
module array_access_stat_tracker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  aast_pkg::in_word_t in_word,
	output logic done,
	output aast_pkg::out_word_t out_word
);
	import aast_pkg::*;
	`include "array_access_stat_tracker_defines.svh"

	logic busy_q;
	logic done_q;
	logic [UsedW-1:0] used_q;
	cell_cmd_t cmd_s1;
	logic [EntW-1:0] sel_s1;
	logic full_s1;
	logic [Entries:0] hit_chain;
	logic [Entries-1:0] match_v;
	cell_stat_t stat_v [Entries];
	logic [Entries-1:0] occ;
	logic ld;
	logic commit;
	logic [EntW-1:0] sel;
	logic miss;
	logic room;
	cell_stat_t st;
	logic [MemAw-1:0] raddr;
	logic [MemAw-1:0] waddr;
	logic [31:0] mrd;
	logic [31:0] hits;
	out_word_t out_q;

	assign busy = busy_q;
	assign done = done_q;
	assign out_word = out_q;
	assign ld = start && !busy_q;

	assign hit_chain[0] = 1'b0;
	genvar g;
	generate
		for (g = 0; g < Entries; g++) begin : g_cell
			assign occ[g] = UsedW'(g) < used_q;
			aast_cell u_cell (
				.clk(clk), .arst_n(arst_n), .my_num(EntW'(g)), .occupied(occ[g]),
				.probe_id(in_word.arr_tag), .load(ld),
				.cmd(cmd_s1), .commit(commit), .hit_in(hit_chain[g]),
				.hit_out(hit_chain[g+1]), .match(match_v[g]), .stat(stat_v[g])
			);
		end
	endgenerate

	// entry picked at accept: the matching cell, else the next free one
	always_comb begin
		sel = used_q[EntW-1:0];
		for (int i = 0; i < Entries; i++)
			if (match_v[i]) sel = EntW'(i);
	end

	assign miss = !hit_chain[Entries];
	assign room = used_q != UsedW'(Entries);
	assign commit = busy_q && !full_s1;
	assign st = stat_v[sel_s1];

	// counter memory addressed by entry and slot; stale data of a slot not yet
	// visited since allocation is masked by the fresh bit
	assign raddr = {sel, in_word.access_index[SlotW-1:0]};
	assign waddr = {sel_s1, cmd_s1.idx[SlotW-1:0]};
	assign hits = (st.fresh ? 32'd0 : mrd) + 32'd1;

	aast_ram #(.Width(32), .Depth(MemDepth)) u_ram (
		.clk(clk), .we(commit), .waddr(waddr), .wdata(hits),
		.raddr(raddr), .rdata(mrd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			used_q <= '0;
			cmd_s1 <= '0;
			sel_s1 <= '0;
			full_s1 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ld) begin
				busy_q <= 1'b1;
				cmd_s1.id <= in_word.arr_tag;
				cmd_s1.idx <= in_word.access_index;
				cmd_s1.alloc <= miss && room;
				cmd_s1.alloc_sel <= used_q[EntW-1:0];
				sel_s1 <= sel;
				full_s1 <= miss && !room;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
				if (commit && cmd_s1.alloc) used_q <= used_q + UsedW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (full_s1) out_q <= '0;
			else begin
				out_q.found <= 1'b1;
				out_q.entry_number <= 4'(sel_s1);
				out_q.total_accesses <= st.count;
				out_q.lowest_index <= st.lo;
				out_q.highest_index <= st.hi;
				out_q.distinct_slots <= 7'(st.dcount);
				out_q.negative_seen <= st.neg;
				out_q.slot_hits <= hits;
				out_q.slot_was_new <= st.fresh;
			end
		end
	end

	`AAST_ASSERT_IMP(a_onehot_match, clk, arst_n, ld, $onehot0(match_v))
	`AAST_ASSERT_NXT(a_one_busy_cycle, clk, arst_n, busy_q, !busy_q && done_q)
	`AAST_ASSERT_IMP(a_used_max, clk, arst_n, 1'b1, used_q <= UsedW'(Entries))
	`AAST_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, !busy_q)
	`AAST_ASSERT_IMP(a_full_no_alloc, clk, arst_n, busy_q && full_s1, !cmd_s1.alloc)
endmodule

>>> src/aast_ram.sv
// ----------------------------------------------------------------------------
// aast_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aast_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

>>> src/aast_cell.sv
// ----------------------------------------------------------------------------
// aast_cell
// One table entry: id match, statistics and visited map for that entry.
// ----------------------------------------------------------------------------
module aast_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic [aast_pkg::EntW-1:0] my_num,
	input  logic occupied,
	input  logic [31:0] probe_id,
	input  logic load,
	input  aast_pkg::cell_cmd_t cmd,
	input  logic commit,
	input  logic hit_in,
	output logic hit_out,
	output logic match,
	output aast_pkg::cell_stat_t stat
);
	import aast_pkg::*;

	logic [31:0] id_q;
	logic [31:0] cnt_q;
	logic signed [63:0] lo_q, hi_q;
	logic neg_q;
	logic [Slots-1:0] map_q;
	logic [DistW-1:0] dcnt_q;
	logic match_s1;
	logic mine, init;
	logic [SlotW-1:0] slot;
	logic [31:0] cnt_b;
	logic signed [63:0] lo_b, hi_b;
	logic [Slots-1:0] map_b;
	logic [DistW-1:0] dcnt_b;
	logic neg_b;

	assign match = occupied && (id_q == probe_id);
	// hit chain passes toward higher cells
	assign hit_out = hit_in | match;
	assign init = cmd.alloc && (cmd.alloc_sel == my_num);
	assign mine = match_s1 || init;
	assign slot = cmd.idx[SlotW-1:0];

	always_comb begin
		cnt_b = init ? 32'd0 : cnt_q;
		lo_b = init ? 64'sh7FFF_FFFF_FFFF_FFFF : lo_q;
		hi_b = init ? 64'sh8000_0000_0000_0000 : hi_q;
		map_b = init ? '0 : map_q;
		dcnt_b = init ? '0 : dcnt_q;
		neg_b = init ? 1'b0 : neg_q;
		stat.fresh = !map_b[slot];
		stat.count = cnt_b + 32'd1;
		stat.lo = (cmd.idx < lo_b) ? cmd.idx : lo_b;
		stat.hi = (cmd.idx > hi_b) ? cmd.idx : hi_b;
		stat.dcount = dcnt_b + DistW'(stat.fresh);
		stat.neg = neg_b | cmd.idx[63];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q <= '0;
			cnt_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			dcnt_q <= '0;
			neg_q <= 1'b0;
			map_q <= '0;
			match_s1 <= 1'b0;
		end else begin
			// match is registered at accept, the update lands in the following cycle
			if (load) match_s1 <= match;
			if (commit && mine) begin
				if (init) id_q <= cmd.id;
				cnt_q <= stat.count;
				lo_q <= stat.lo;
				hi_q <= stat.hi;
				dcnt_q <= stat.dcount;
				neg_q <= stat.neg;
				map_q <= map_b | (Slots'(1) << slot);
			end
		end
	end
endmodule

>>> bench/access_stat_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// access_stat_checker
// Watches the request and result channels of the tracker, predicts each
// result from a private copy of the table and compares it as a whole word.
// ----------------------------------------------------------------------------
module access_stat_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  aast_pkg::in_word_t in_word,
	input  logic done,
	input  aast_pkg::out_word_t out_word,
	output int fail_count,
	output int pending
);
	import aast_pkg::*;

	logic [31:0] tbl_id [Entries];
	int used;
	logic [31:0] acc_cnt [Entries];
	logic signed [63:0] lo_idx [Entries];
	logic signed [63:0] hi_idx [Entries];
	logic neg_flag [Entries];
	logic [Slots-1:0] visited [Entries];
	logic [6:0] dist_cnt [Entries];
	logic [31:0] slot_cnt [Entries][Slots];
	out_word_t expected_q [$];

	function automatic out_word_t track_access(in_word_t w);
		out_word_t r;
		int e;
		int s;
		bit hit;
		r = '0;
		hit = 1'b0;
		e = 0;
		for (int i = 0; i < used; i++) begin
			if (!hit && tbl_id[i] == w.arr_tag) begin
				hit = 1'b1;
				e = i;
			end
		end
		if (!hit) begin
			if (used >= Entries)
				return r;
			e = used;
			used++;
			tbl_id[e] = w.arr_tag;
			acc_cnt[e] = '0;
			lo_idx[e] = 64'sh7fffffffffffffff;
			hi_idx[e] = 64'sh8000000000000000;
			neg_flag[e] = 1'b0;
			visited[e] = '0;
			dist_cnt[e] = '0;
			for (int k = 0; k < Slots; k++)
				slot_cnt[e][k] = '0;
		end
		acc_cnt[e] = acc_cnt[e] + 32'd1;
		if (w.access_index < lo_idx[e])
			lo_idx[e] = w.access_index;
		if (w.access_index > hi_idx[e])
			hi_idx[e] = w.access_index;
		// fold the raw bit pattern
		s = int'(w.access_index[SlotW-1:0]);
		r.slot_was_new = !visited[e][s];
		if (!visited[e][s]) begin
			visited[e][s] = 1'b1;
			dist_cnt[e] = dist_cnt[e] + 7'd1;
		end
		slot_cnt[e][s] = slot_cnt[e][s] + 32'd1;
		if (w.access_index[63])
			neg_flag[e] = 1'b1;
		r.found = 1'b1;
		r.entry_number = e[3:0];
		r.total_accesses = acc_cnt[e];
		r.lowest_index = lo_idx[e];
		r.highest_index = hi_idx[e];
		r.distinct_slots = dist_cnt[e];
		r.negative_seen = neg_flag[e];
		r.slot_hits = slot_cnt[e][s];
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			used = 0;
			fail_count = 0;
			expected_q.delete();
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word %h", out_word);
				end else begin
					want = expected_q.pop_front();
					if (want !== out_word) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p actual %p", want, out_word);
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(track_access(in_word));
		end
	end
endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives access reports into the tracker: directed corners, table overflow,
// then bursts of random reports over a few reused ids. A checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
	import aast_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_word_t in_word;
	logic done;
	out_word_t out_word;
	int fail_count;
	int pending;
	logic [31:0] id_pool [8];

	array_access_stat_tracker u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_word(in_word),
		.done(done),
		.out_word(out_word)
	);

	access_stat_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_word(in_word),
		.done(done),
		.out_word(out_word),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// hold a word until taken
	task automatic send_word(logic [31:0] id, logic [63:0] idx);
		start <= 1'b1;
		in_word <= '{arr_tag: id, access_index: idx};
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic logic [63:0] rand_index();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: v = 64'sh7fffffffffffffff;
			1: v = 64'sh8000000000000000;
			2: v = 64'(signed'($urandom_range(0, 200)) - 100);
			3: v = {58'b0, 6'($urandom)};
			default: ;
		endcase
		return v;
	endfunction

	initial begin
		#20000000;
		$display("array_access_stat_tracker verification failed");
		$finish;
	end

	initial begin
		int burst;
		int sent;
		int drain;
		start = 1'b0;
		in_word = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed corners on two ids
		send_word(32'h0, 64'h0);
		send_word(32'h0, 64'h7fffffffffffffff);
		send_word(32'h0, 64'h8000000000000000);
		send_word(32'h0, 64'hffffffffffffffff);
		send_word(32'h0, 64'h0);
		send_word(32'hffffffff, 64'h0000000000000040);
		send_word(32'hffffffff, 64'hffffffffffffffc0);
		// fill the table, then overflow it
		for (int i = 2; i < 18; i++)
			send_word(32'h1000 + i, 64'(i));
		send_word(32'h0, 64'h5);
		send_word(32'haaaa5555, 64'h3);
		start <= 1'b0;
		for (int i = 0; i < 8; i++)
			id_pool[i] = (i < 6) ? 32'h1000 + 2 + i : $urandom;
		sent = 0;
		while (sent < 1700) begin
			burst = $urandom_range(1, 20);
			for (int b = 0; b < burst; b++) begin
				if ($urandom_range(0, 9) == 0)
					send_word($urandom, rand_index());
				else
					send_word(id_pool[$urandom_range(0, 7)], rand_index());
				sent++;
			end
			start <= 1'b0;
			if ($urandom_range(0, 2) != 0)
				repeat ($urandom_range(1, 6)) @(posedge clk);
			else
				@(posedge clk);
		end
		start <= 1'b0;
		drain = 0;
		while (pending != 0 && drain < 1000) begin
			@(posedge clk);
			drain++;
		end
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("array_access_stat_tracker verification clean");
		else
			$display("array_access_stat_tracker verification failed");
		$finish;
	end
endmodule
